// ----- rtl/core/rfid_inventory_response_parser_defines.svh -----
// ---------------------------------------------------------------------------
// rfid_inventory_response_parser_defines
// Assertion macros shared by the inventory response parser modules.
// ---------------------------------------------------------------------------
`ifndef RFID_INVENTORY_RESPONSE_PARSER_DEFINES_SVH
`define RFID_INVENTORY_RESPONSE_PARSER_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define RIP_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("rip invariant violated");

// condition that implies another in the same cycle
`define RIP_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rip implication violated");

// condition that implies another in the next cycle
`define RIP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rip next-cycle check violated");

`endif

// ----- rtl/core/rip_pkg.sv -----
// ---------------------------------------------------------------------------
// rip_pkg
// Types, byte codes and helpers for the inventory response parser.
// ---------------------------------------------------------------------------
package rip_pkg;

  // default sizing
  localparam int DEF_MAX_FRAME = 256;
  localparam int DEF_MAX_TAGS  = 16;
  localparam int QUEUE_DEPTH   = 4;

  // field widths
  localparam int COUNT_W = 14;
  localparam int LEN_W   = 9;
  localparam int UID_W   = 64;
  localparam int IDX_W   = 4;

  // framing bytes
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;

  // payload layout
  localparam int COUNT_FIRST = 4;
  localparam int UID_FIRST   = 8;

  // result kinds
  localparam logic KIND_TAG = 1'b0;
  localparam logic KIND_END = 1'b1;

  // frame phase seen by the front end
  typedef enum logic [1:0] {
    PH_ACK  = 2'd0,
    PH_STX  = 2'd1,
    PH_BODY = 2'd2,
    PH_CSUM = 2'd3
  } phase_t;

  // command classes handed from front to back
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_HDR   = 3'd1,
    OP_OVF   = 3'd2,
    OP_DIGIT = 3'd3,
    OP_HEX   = 3'd4,
    OP_END   = 3'd5
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             bad;    // header mismatch, non-digit or non-hex
    logic [7:0]       data;   // digit or nibble value, or checksum byte
    logic [LEN_W-1:0] len;    // saturated payload length
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nib;
  } hex_t;

  // ascii hex character to nibble
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.valid = 1'b1;
    r.nib   = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nib = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r.nib = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/rip_front.sv -----
// ---------------------------------------------------------------------------
// rip_front
// Tracks framing phase and payload position and classifies each byte.
// ---------------------------------------------------------------------------
module rip_front #(
  parameter int MAX_FRAME = rip_pkg::DEF_MAX_FRAME
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    rx_byte,
  input  logic          q_full,
  output logic          push,
  output rip_pkg::cmd_t cmd
);
  import rip_pkg::*;

  localparam int PW = $clog2(MAX_FRAME + 1);

  phase_t        phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic          at_max;
  logic          is_etx;
  hex_t          hv;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign at_max   = (pos >= PW'(MAX_FRAME));
  assign is_etx   = (rx_byte == BYTE_ETX);
  assign hv       = hex_decode(rx_byte);

  // phase transitions
  always_comb begin
    phase_next = phase;
    if (push) begin
      case (phase)
        PH_ACK:  phase_next = PH_STX;
        PH_STX:  phase_next = PH_BODY;
        PH_BODY: phase_next = is_etx ? PH_CSUM : PH_BODY;
        PH_CSUM: phase_next = PH_ACK;
        default: phase_next = PH_ACK;
      endcase
    end
  end

  // payload position, saturating at the buffer size
  always_comb begin
    pos_next = pos;
    if (push) begin
      if (phase == PH_CSUM) begin
        pos_next = '0;
      end else if (phase == PH_BODY && !is_etx && !at_max) begin
        pos_next = pos + PW'(1);
      end
    end
  end

  // byte classification
  always_comb begin
    cmd.op   = OP_NOP;
    cmd.bad  = 1'b0;
    cmd.data = rx_byte;
    cmd.len  = LEN_W'(pos);
    case (phase)
      PH_ACK: begin
        cmd.op  = OP_HDR;
        cmd.bad = (rx_byte != BYTE_ACK);
      end
      PH_STX: begin
        cmd.op  = OP_HDR;
        cmd.bad = (rx_byte != BYTE_STX);
      end
      PH_BODY: begin
        if (is_etx) begin
          cmd.op = OP_NOP;
        end else if (at_max) begin
          cmd.op = OP_OVF;
        end else if (pos >= PW'(UID_FIRST)) begin
          cmd.op   = OP_HEX;
          cmd.bad  = !hv.valid;
          cmd.data = {4'd0, hv.nib};
        end else if (pos >= PW'(COUNT_FIRST)) begin
          cmd.op   = OP_DIGIT;
          cmd.bad  = !(rx_byte >= 8'h30 && rx_byte <= 8'h39);
          cmd.data = {4'd0, rx_byte[3:0]};
        end
      end
      PH_CSUM: cmd.op = OP_END;
      default: cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ACK;
      pos   <= '0;
    end else begin
      phase <= phase_next;
      pos   <= pos_next;
    end
  end

endmodule

// ----- rtl/core/rip_queue.sv -----
// ---------------------------------------------------------------------------
// rip_queue
// Small command queue between the classifier and the parser back end.
// ---------------------------------------------------------------------------
`include "rfid_inventory_response_parser_defines.svh"

module rip_queue #(
  parameter int DEPTH = rip_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rip_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rip_pkg::cmd_t rd_cmd
);
  import rip_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  `RIP_ASSERT_ALWAYS(a_count_range, count <= CW'(DEPTH))
  `RIP_ASSERT_NEXT(a_push_only_fills, do_push && !do_pop, !empty)

endmodule

// ----- rtl/core/rip_back.sv -----
// ---------------------------------------------------------------------------
// rip_back
// Executes classified commands: count, uid assembly, flags and results.
// ---------------------------------------------------------------------------
`include "rfid_inventory_response_parser_defines.svh"

module rip_back #(
  parameter int MAX_TAGS = rip_pkg::DEF_MAX_TAGS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  rip_pkg::cmd_t                 cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          result_kind,
  output logic [rip_pkg::UID_W-1:0]     uid,
  output logic [rip_pkg::IDX_W-1:0]     tag_index,
  output logic [rip_pkg::COUNT_W-1:0]   tag_count,
  output logic [rip_pkg::LEN_W-1:0]     frame_length,
  output logic [7:0]                    checksum_byte,
  output logic                          header_error,
  output logic                          hex_error,
  output logic                          overflow
);
  import rip_pkg::*;

  localparam int TW = $clog2(MAX_TAGS + 1);

  // parser state
  logic [COUNT_W-1:0] count_acc, count_acc_next;
  logic               count_stop, count_stop_next;
  logic [UID_W-1:0]   uid_acc, uid_acc_next;
  logic [3:0]         nib_cnt, nib_cnt_next;
  logic [TW-1:0]      tags, tags_next;
  logic [2:0]         flags, flags_next;

  // result being formed
  logic               load;
  logic               r_kind;
  logic [UID_W-1:0]   r_uid;
  logic [2:0]         r_flags;
  logic [5:0]         sh;
  logic               tag_open;

  assign pop      = !q_empty && (!out_valid || !out_stall);
  assign sh       = {nib_cnt[3:1], ~nib_cnt[0], 2'b00};
  assign tag_open = ({{(COUNT_W - TW){1'b0}}, tags} < count_acc)
                    && (tags < TW'(MAX_TAGS));

  // command execution
  always_comb begin
    count_acc_next  = count_acc;
    count_stop_next = count_stop;
    uid_acc_next    = uid_acc;
    nib_cnt_next    = nib_cnt;
    tags_next       = tags;
    flags_next      = flags;
    load            = 1'b0;
    r_kind          = KIND_TAG;
    r_uid           = '0;
    r_flags         = flags;
    if (pop) begin
      case (cmd.op)
        OP_HDR: begin
          if (cmd.bad) flags_next[0] = 1'b1;
        end
        OP_OVF: flags_next[2] = 1'b1;
        OP_DIGIT: begin
          if (!count_stop) begin
            if (cmd.bad) begin
              count_stop_next = 1'b1;
            end else begin
              count_acc_next = COUNT_W'((count_acc << 3) + (count_acc << 1)
                                        + COUNT_W'(cmd.data[3:0]));
            end
          end
        end
        OP_HEX: begin
          if (tag_open) begin
            if (cmd.bad) flags_next[1] = 1'b1;
            uid_acc_next          = uid_acc;
            uid_acc_next[sh +: 4] = cmd.bad ? 4'd0 : cmd.data[3:0];
            if (nib_cnt == 4'd15) begin
              load         = 1'b1;
              r_kind       = KIND_TAG;
              r_uid        = uid_acc_next;
              r_flags      = flags_next;
              tags_next    = tags + TW'(1);
              uid_acc_next = '0;
              nib_cnt_next = 4'd0;
            end else begin
              nib_cnt_next = nib_cnt + 4'd1;
            end
          end
        end
        OP_END: begin
          load    = 1'b1;
          r_kind  = KIND_END;
          r_flags = flags;
          if (count_acc > COUNT_W'(MAX_TAGS)) r_flags[2] = 1'b1;
          count_acc_next  = '0;
          count_stop_next = 1'b0;
          uid_acc_next    = '0;
          nib_cnt_next    = 4'd0;
          tags_next       = '0;
          flags_next      = '0;
        end
        default: ;
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_acc  <= '0;
      count_stop <= 1'b0;
      uid_acc    <= '0;
      nib_cnt    <= 4'd0;
      tags       <= '0;
      flags      <= '0;
    end else begin
      count_acc  <= count_acc_next;
      count_stop <= count_stop_next;
      uid_acc    <= uid_acc_next;
      nib_cnt    <= nib_cnt_next;
      tags       <= tags_next;
      flags      <= flags_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      result_kind   <= r_kind;
      uid           <= r_uid;
      tag_index     <= (r_kind == KIND_TAG) ? IDX_W'(tags) : '0;
      tag_count     <= count_acc;
      frame_length  <= (r_kind == KIND_END) ? cmd.len : '0;
      checksum_byte <= (r_kind == KIND_END) ? cmd.data : 8'd0;
      header_error  <= r_flags[0];
      hex_error     <= r_flags[1];
      overflow      <= r_flags[2];
    end
  end

  `RIP_ASSERT_ALWAYS(a_tags_bounded, tags <= TW'(MAX_TAGS))
  `RIP_ASSERT_IMPLIES(a_tag_within_count, load && r_kind == KIND_TAG, tag_open)
  `RIP_ASSERT_NEXT(a_end_clears, load && r_kind == KIND_END,
                   tags == '0 && nib_cnt == 4'd0 && flags == '0)

endmodule

// ----- rtl/core/rfid_inventory_response_parser.sv -----
// ---------------------------------------------------------------------------
// rfid_inventory_response_parser
// Parses inventory replies from a serial RFID reader into tag results.
// ---------------------------------------------------------------------------
// Input channel: one received byte per transfer on rx_byte (in_valid/in_stall).
// Output channel: one result per transfer (out_valid/out_stall); result_kind
// tells a tag uid result from the frame end result that closes each reply.
// A front end tracks the ACK, STX, payload and checksum phases and classifies
// every byte; a four-entry command queue feeds the back end, which builds the
// tag count and the uids and loads the output register.
// Throughput: one byte per cycle while the command queue has room; the classifier
// and command execution are combinational. The byte that completes a result
// passes through the command queue, behind any queued commands, to the output register.
// When the receiver stalls, the held result stays put; the back end stops
// draining, and in_stall rises once all four queue entries are taken.
// Reset (rst, synchronous) empties the queue, drops any pending result and
// returns the parser to expecting the ACK slot of a new reply.
// ---------------------------------------------------------------------------
module rfid_inventory_response_parser #(
  parameter int MAX_FRAME = rip_pkg::DEF_MAX_FRAME,
  parameter int MAX_TAGS  = rip_pkg::DEF_MAX_TAGS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          result_kind,
  output logic [rip_pkg::UID_W-1:0]     uid,
  output logic [rip_pkg::IDX_W-1:0]     tag_index,
  output logic [rip_pkg::COUNT_W-1:0]   tag_count,
  output logic [rip_pkg::LEN_W-1:0]     frame_length,
  output logic [7:0]                    checksum_byte,
  output logic                          header_error,
  output logic                          hex_error,
  output logic                          overflow
);
  import rip_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic push, q_full, q_empty, pop;

  // byte classification
  rip_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  // decoupling queue
  rip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (front_cmd),
    .full   (q_full),
    .pop    (pop),
    .empty  (q_empty),
    .rd_cmd (back_cmd)
  );

  // command execution and result register
  rip_back #(
    .MAX_TAGS (MAX_TAGS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .cmd           (back_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .uid           (uid),
    .tag_index     (tag_index),
    .tag_count     (tag_count),
    .frame_length  (frame_length),
    .checksum_byte (checksum_byte),
    .header_error  (header_error),
    .hex_error     (hex_error),
    .overflow      (overflow)
  );

endmodule

// ----- verif/rfid_inventory_response_parser_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rfid_inventory_response_parser_tb
// Feeds reader replies byte by byte into the inventory response parser and
// checks every tag uid and frame end result against a cycle-free parser
// model kept in a small scoreboard. Replies are mostly well formed with
// random content (counts, uids, lengths), mixed with bad headers, short and
// long payloads, bad hex and raw noise. Both channels idle and stall in
// random bursts, and one long output hold-off backs the parser up.
// ---------------------------------------------------------------------------
module rfid_inventory_response_parser_tb;
  import rip_pkg::*;

  localparam int MAX_FRAME   = DEF_MAX_FRAME;
  localparam int MAX_TAGS    = DEF_MAX_TAGS;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 150;
  localparam int BYTE_TARGET = 1500;
  localparam int QUIET_AFTER = 1300;

  // one result as seen on the output channel
  typedef struct {
    logic                kind;
    logic [UID_W-1:0]    uid;
    logic [IDX_W-1:0]    idx;
    logic [COUNT_W-1:0]  count;
    logic [LEN_W-1:0]    len;
    logic [7:0]          csum;
    logic                hdr;
    logic                hex;
    logic                ovf;
  } parse_result_t;

  // parser model plus the results it still waits for
  class reply_scoreboard;
    phase_t          phase;
    int unsigned     pos;
    int unsigned     count;
    bit              count_done;
    logic [63:0]     uid_acc;
    logic [3:0]      nib_pos;
    int unsigned     tags;
    bit              hdr_err;
    bit              hex_err;
    bit              ovf_err;
    parse_result_t   awaited_results[$];
    int unsigned     errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase      = PH_ACK;
      pos        = 0;
      count      = 0;
      count_done = 1'b0;
      uid_acc    = '0;
      nib_pos    = '0;
      tags       = 0;
      hdr_err    = 1'b0;
      hex_err    = 1'b0;
      ovf_err    = 1'b0;
    endfunction

    function int hex_nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      return -1;
    endfunction

    function void push_result(logic kind, logic [63:0] uid, logic [8:0] len,
                              logic [7:0] csum);
      parse_result_t r;
      r.kind  = kind;
      r.uid   = uid;
      r.idx   = (kind == KIND_TAG) ? tags[3:0] : 4'd0;
      r.count = count[COUNT_W-1:0];
      r.len   = len;
      r.csum  = csum;
      r.hdr   = hdr_err;
      r.hex   = hex_err;
      r.ovf   = ovf_err | (kind == KIND_END && count > MAX_TAGS);
      awaited_results.push_back(r);
    endfunction

    // advance the model by one accepted byte
    function void take_byte(logic [7:0] b);
      int          nib;
      int unsigned slot;
      int unsigned sh;
      case (phase)
        PH_ACK: begin
          if (b != BYTE_ACK) hdr_err = 1'b1;
          phase = PH_STX;
        end
        PH_STX: begin
          if (b != BYTE_STX) hdr_err = 1'b1;
          phase = PH_BODY;
        end
        PH_BODY: begin
          if (b == BYTE_ETX) begin
            phase = PH_CSUM;
          end else if (pos >= MAX_FRAME) begin
            ovf_err = 1'b1;
          end else begin
            slot = pos;
            pos  = pos + 1;
            if (slot >= COUNT_FIRST && slot < UID_FIRST) begin
              // decimal count, frozen at the first non-digit
              if (!count_done) begin
                if (b >= 8'h30 && b <= 8'h39) count = count * 10 + int'(b - 8'h30);
                else count_done = 1'b1;
              end
            end else if (slot >= UID_FIRST && tags < count && tags < MAX_TAGS) begin
              // high nibble first within each byte, first byte lowest
              nib = hex_nibble(b);
              if (nib < 0) begin
                hex_err = 1'b1;
                nib = 0;
              end
              sh = 8 * nib_pos[3:1] + (nib_pos[0] ? 0 : 4);
              uid_acc = uid_acc | (64'(nib) << sh);
              if (nib_pos == 4'd15) begin
                push_result(KIND_TAG, uid_acc, 9'd0, 8'd0);
                tags    = tags + 1;
                uid_acc = '0;
                nib_pos = '0;
              end else begin
                nib_pos = nib_pos + 4'd1;
              end
            end
          end
        end
        default: begin
          push_result(KIND_END, 64'd0, pos[8:0], b);
          clear_frame();
        end
      endcase
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, actual %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d uid %0h", got.kind, got.uid);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("result_kind", 64'(want.kind), 64'(got.kind));
      compare_field("uid", want.uid, got.uid);
      compare_field("tag_index", 64'(want.idx), 64'(got.idx));
      compare_field("tag_count", 64'(want.count), 64'(got.count));
      compare_field("frame_length", 64'(want.len), 64'(got.len));
      compare_field("checksum_byte", 64'(want.csum), 64'(got.csum));
      compare_field("header_error", 64'(want.hdr), 64'(got.hdr));
      compare_field("hex_error", 64'(want.hex), 64'(got.hex));
      compare_field("overflow", 64'(want.ovf), 64'(got.ovf));
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          rx_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                result_kind;
  logic [UID_W-1:0]    uid;
  logic [IDX_W-1:0]    tag_index;
  logic [COUNT_W-1:0]  tag_count;
  logic [LEN_W-1:0]    frame_length;
  logic [7:0]          checksum_byte;
  logic                header_error;
  logic                hex_error;
  logic                overflow;

  reply_scoreboard     sb;
  logic [7:0]          reply_bytes[$];
  int unsigned         bytes_sent = 0;
  int unsigned         idle_cycles = 0;
  bit                  sender_gaps = 1'b0;
  bit                  quiet_tail = 1'b0;
  bit                  hold_request = 1'b0;

  rfid_inventory_response_parser uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .uid           (uid),
    .tag_index     (tag_index),
    .tag_count     (tag_count),
    .frame_length  (frame_length),
    .checksum_byte (checksum_byte),
    .header_error  (header_error),
    .hex_error     (hex_error),
    .overflow      (overflow)
  );

  always #2 clk = ~clk;

  // check every result transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result('{result_kind, uid, tag_index, tag_count, frame_length,
                        checksum_byte, header_error, hex_error, overflow});
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off, none in the tail
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_taken) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_taken = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // one byte transfer, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_reply();
    foreach (reply_bytes[i]) send_byte(reply_bytes[i]);
  endtask

  // close whatever frame the parser is in
  task automatic resync();
    while (sb.phase != PH_ACK) send_byte(BYTE_ETX);
  endtask

  function automatic logic [7:0] any_but_etx();
    logic [7:0] r;
    do r = 8'($urandom); while (r == BYTE_ETX);
    return r;
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] r;
    do r = any_but_etx(); while (r >= 8'h30 && r <= 8'h39);
    return r;
  endfunction

  function automatic void push_decimal(int unsigned n, int unsigned digits);
    int unsigned divisor;
    int unsigned i;
    divisor = 1;
    for (i = 1; i < digits; i++) divisor = divisor * 10;
    for (i = 0; i < digits; i++) begin
      reply_bytes.push_back(8'(8'h30 + (n / divisor) % 10));
      divisor = divisor / 10;
    end
  endfunction

  // one random reply: header, filler, count field, uids, ETX, checksum
  function automatic void build_reply(input bit force_long);
    int unsigned n;
    int unsigned k;
    int unsigned want_tags;
    int unsigned n_chars;
    int unsigned mode;
    int unsigned style;
    int unsigned target;
    int unsigned i;
    string       hex_set;
    hex_set = "0123456789ABCDEFabcdef";
    style = 3;
    reply_bytes.delete();
    reply_bytes.push_back(($urandom_range(0, 11) == 0) ? 8'($urandom) : BYTE_ACK);
    reply_bytes.push_back(($urandom_range(0, 11) == 0) ? 8'($urandom) : BYTE_STX);
    for (i = 0; i < COUNT_FIRST; i++) reply_bytes.push_back(any_but_etx());
    // count field: padded decimal, cut short, huge or garbage
    mode = $urandom_range(0, 19);
    if (mode < 14) begin
      n = (mode < 12) ? $urandom_range(0, 3) : $urandom_range(14, 18);
      push_decimal(n, 4);
    end else if (mode < 17) begin
      k = $urandom_range(0, 3);
      n = $urandom_range(0, 10 ** k - 1);
      push_decimal(n, k);
      for (i = k; i < 4; i++) reply_bytes.push_back((i == k) ? non_digit() : any_but_etx());
    end else if (mode == 17) begin
      n = $urandom_range(17, 9999);
      push_decimal(n, 4);
    end else begin
      n = 1000;
      for (i = 0; i < 4; i++) reply_bytes.push_back(any_but_etx());
    end
    want_tags = (n > 18) ? $urandom_range(0, 3) : n;
    if ($urandom_range(0, 5) == 0) want_tags++;
    n_chars = want_tags * 16;
    if (n_chars > 0 && $urandom_range(0, 6) == 0) n_chars -= $urandom_range(1, 15);
    // uid characters, some tags all zeros or all ones
    for (i = 0; i < n_chars; i++) begin
      if (i % 16 == 0) style = $urandom_range(0, 9);
      if (style == 0) reply_bytes.push_back(8'h30);
      else if (style == 1) reply_bytes.push_back(8'h46);
      else if (style == 2) reply_bytes.push_back(8'h66);
      else if ($urandom_range(0, 24) == 0) reply_bytes.push_back(any_but_etx());
      else reply_bytes.push_back(hex_set[$urandom_range(0, 21)]);
    end
    // short payload
    if ($urandom_range(0, 11) == 0) begin
      target = 2 + $urandom_range(0, UID_FIRST - 1);
      while (reply_bytes.size() > target) void'(reply_bytes.pop_back());
    end
    // payload past the buffer
    if (force_long || $urandom_range(0, 39) == 0) begin
      target = 2 + $urandom_range(MAX_FRAME - 6, MAX_FRAME + 44);
      while (reply_bytes.size() < target) reply_bytes.push_back(any_but_etx());
    end
    reply_bytes.push_back(BYTE_ETX);
    reply_bytes.push_back(8'($urandom));
  endfunction

  // stimulus
  initial begin
    int unsigned reply_no;
    bit          hold_done;
    sb = new();
    reply_no  = 0;
    hold_done = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bad ack and stx, empty payload, checksum all ones
    reply_bytes = '{8'h00, 8'hFF, BYTE_ETX, 8'hFF};
    send_reply();
    // short payload, count cut by a non-digit
    reply_bytes = '{BYTE_ACK, BYTE_STX, 8'h41, 8'h42, 8'h43, 8'h44, 8'h31, 8'h32,
                    8'h78, BYTE_ETX, 8'h00};
    send_reply();
    // count above tag capacity with no uids
    reply_bytes = '{BYTE_ACK, BYTE_STX, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,
                    8'h39, 8'h39, BYTE_ETX, 8'h5A};
    send_reply();

    // random replies with some raw noise
    while (bytes_sent < BYTE_TARGET) begin
      quiet_tail  = (bytes_sent >= QUIET_AFTER);
      sender_gaps = !quiet_tail && ($urandom_range(0, 9) < 7);
      if (!hold_done && bytes_sent > 500) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(5, 40)) send_byte(8'($urandom));
        resync();
      end else begin
        build_reply(reply_no == 3);
        send_reply();
        reply_no++;
      end
    end
    in_valid <= 1'b0;

    // drain and let any stray result show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
